// ===== hdl/dfl_pkg.sv =====
// ============================================================================
// dfl_pkg: shared types and constants for the dated rate floor lookup
// Entry layout, date and amount limits, status codes and sequencer states.
// ============================================================================
package dfl_pkg;

    // Field widths
    localparam int YEAR_W     = 14;
    localparam int MD_W       = 7;
    localparam int RATE_W     = 32;
    localparam int AMT_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int PROD_W     = 42;

    // Largest key is 16383*10000 + 127*100 + 127, which needs 28 bits
    localparam int KEY_W      = 28;

    // An accepted amount is at most 4096000, which fits in 22 bits
    localparam int MUL_A_W    = 22;
    localparam int PROD_FULL_W = MUL_A_W + RATE_W;
    localparam int FRAC_SHIFT = 12;

    // Key scaling
    localparam int YEAR_SCALE  = 10000;
    localparam int MONTH_SCALE = 100;

    // Query date window and amount limit (1000.0 in Q19.12)
    localparam logic [YEAR_W-1:0] YEAR_MIN  = 14'd2009;
    localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd2024;
    localparam logic [MD_W-1:0]   MONTH_MIN = 7'd1;
    localparam logic [MD_W-1:0]   MONTH_MAX = 7'd12;
    localparam logic [MD_W-1:0]   DAY_MIN   = 7'd1;
    localparam logic [MD_W-1:0]   DAY_MAX   = 7'd31;
    localparam logic [AMT_W-1:0]  AMOUNT_LIMIT = 32'd4096000;

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_DATE  = 3'd1,
        ST_NEGATIVE  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_FULL      = 3'd4,
        ST_LOADED    = 3'd5
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
    } entry_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        status_t          status;
    } check_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_PROBE,
        S_MATCH,
        S_PREV,
        S_SHIFT,
        S_INSERT,
        S_MUL,
        S_DONE
    } state_t;

endpackage

// ===== hdl/dfl_ram.sv =====
// ============================================================================
// dfl_ram: entry memory
// One write port, one read port, registered read data.
// ============================================================================
module dfl_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  dfl_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output dfl_pkg::entry_t rd_data
);

    dfl_pkg::entry_t mem [DEPTH];
    dfl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dfl_key.sv =====
// ============================================================================
// dfl_key: date key and query check
// Form the date key and the query status on capture, hold them registered.
// ============================================================================
module dfl_key (
    input  logic                         clk,
    input  logic                         load,
    input  logic [dfl_pkg::YEAR_W-1:0]   year,
    input  logic [dfl_pkg::MD_W-1:0]     month,
    input  logic [dfl_pkg::MD_W-1:0]     day,
    input  logic [dfl_pkg::AMT_W-1:0]    amount,
    output dfl_pkg::check_t              chk
);

    logic [dfl_pkg::KEY_W-1:0] year_term;
    logic [dfl_pkg::KEY_W-1:0] month_term;
    dfl_pkg::check_t           chk_next;
    dfl_pkg::check_t           chk_reg;

    always_comb
    begin
        year_term  = dfl_pkg::KEY_W'(year)
                   * dfl_pkg::KEY_W'(dfl_pkg::YEAR_SCALE);
        month_term = dfl_pkg::KEY_W'(month)
                   * dfl_pkg::KEY_W'(dfl_pkg::MONTH_SCALE);
        chk_next.key = year_term + month_term + dfl_pkg::KEY_W'(day);

        // Date first, then sign, then the upper amount limit
        priority if (year < dfl_pkg::YEAR_MIN || year > dfl_pkg::YEAR_MAX ||
                     month < dfl_pkg::MONTH_MIN || month > dfl_pkg::MONTH_MAX ||
                     day < dfl_pkg::DAY_MIN || day > dfl_pkg::DAY_MAX)
        begin
            chk_next.status = dfl_pkg::ST_BAD_DATE;
        end
        else if (amount[dfl_pkg::AMT_W-1])
        begin
            chk_next.status = dfl_pkg::ST_NEGATIVE;
        end
        else if (amount > dfl_pkg::AMOUNT_LIMIT)
        begin
            chk_next.status = dfl_pkg::ST_TOO_LARGE;
        end
        else
        begin
            chk_next.status = dfl_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chk_reg <= chk_next;
        end
    end

    assign chk = chk_reg;

endmodule

// ===== hdl/dated_rate_floor_lookup_core.sv =====
// Search: loads and queries both run a binary search that reads one entry a cycle.
// Load: a new key, if there is room, first moves each entry at or above its slot up one place.
// Throughput: one request in flight; the next request is taken once the result
//   reaches the output register, which may still be waiting to be taken.
// Reset: asynchronous, active low; empties the table, memory contents are kept.
// ============================================================================
// dated_rate_floor_lookup_core: sorted dated rate table with floor lookup
// Load requests insert or overwrite rates in key order; query requests find
// the rate at or before a date and return amount times rate.
// ============================================================================
module dated_rate_floor_lookup_core #(
    parameter int ENTRIES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [dfl_pkg::YEAR_W-1:0]      year,
    input  logic [dfl_pkg::MD_W-1:0]        month,
    input  logic [dfl_pkg::MD_W-1:0]        day,
    input  logic [dfl_pkg::RATE_W-1:0]      rate,
    input  logic signed [dfl_pkg::AMT_W-1:0] amount,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dfl_pkg::STATUS_W-1:0]    status,
    output logic [dfl_pkg::PROD_W-1:0]      product,
    output logic [dfl_pkg::RATE_W-1:0]      rate_used,
    output logic                            found
);

    // Index width for entries, and count width that also holds ENTRIES itself
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    dfl_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------------
    // Request payload and working registers
    // ------------------------------------------------------------------------
    logic                              op_reg, op_next;
    logic [dfl_pkg::RATE_W-1:0]        rate_in_reg, rate_in_next;
    logic [dfl_pkg::MUL_A_W-1:0]       amt_reg, amt_next;
    logic [CW-1:0]                     lo_reg, lo_next;
    logic [CW-1:0]                     hi_reg, hi_next;
    logic [CW-1:0]                     mid_reg, mid_next;
    logic [CW-1:0]                     pos_reg, pos_next;
    logic [AW-1:0]                     sh_reg, sh_next;
    logic [dfl_pkg::RATE_W-1:0]        used_reg, used_next;
    logic                              found_reg, found_next;
    dfl_pkg::status_t                  res_status_reg, res_status_next;
    logic [dfl_pkg::PROD_FULL_W-1:0]   prod_reg, prod_next;

    // Output register
    dfl_pkg::status_t                  out_status_reg, out_status_next;
    logic [dfl_pkg::PROD_W-1:0]        out_prod_reg, out_prod_next;
    logic [dfl_pkg::RATE_W-1:0]        out_rate_reg, out_rate_next;
    logic                              out_found_reg, out_found_next;

    // Search step temporaries
    logic [CW-1:0]                     lo_t;
    logic [CW-1:0]                     hi_t;
    logic [CW:0]                       span_sum;
    logic                              key_eq;
    logic                              table_full;

    // ------------------------------------------------------------------------
    // Key unit and entry memory
    // ------------------------------------------------------------------------
    logic              key_load;
    dfl_pkg::check_t   chk;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    dfl_pkg::entry_t   ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    dfl_pkg::entry_t   ram_rd_data;

    dfl_key u_key (
        .clk    (clk),
        .load   (key_load),
        .year   (year),
        .month  (month),
        .day    (day),
        .amount (amount),
        .chk    (chk)
    );

    dfl_ram #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign table_full = (count_reg == CW'(ENTRIES));
    assign key_eq     = (ram_rd_data.key == chk.key);

    // ------------------------------------------------------------------------
    // Sequencer: next state, memory accesses and working register updates
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        rate_in_next    = rate_in_reg;
        amt_next        = amt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        sh_next         = sh_reg;
        used_next       = used_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        prod_next       = prod_reg;
        out_status_next = out_status_reg;
        out_prod_next   = out_prod_reg;
        out_rate_next   = out_rate_reg;
        out_found_next  = out_found_reg;

        in_stall    = 1'b1;
        key_load    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        lo_t        = lo_reg;
        hi_t        = hi_reg;
        span_sum    = '0;

        // Drop the delivered result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dfl_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    key_load     = 1'b1;
                    op_next      = opcode;
                    rate_in_next = rate;
                    amt_next     = amount[dfl_pkg::MUL_A_W-1:0];
                    state_next   = dfl_pkg::S_START;
                end
            end

            dfl_pkg::S_START:
            begin
                used_next  = '0;
                found_next = 1'b0;
                prod_next  = '0;
                if (op_reg == dfl_pkg::OP_QUERY && chk.status != dfl_pkg::ST_OK)
                begin
                    // Rejected query: report the check result at once
                    res_status_next = chk.status;
                    state_next      = dfl_pkg::S_DONE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    mid_next   = count_reg >> 1;
                    pend_next  = (count_reg != '0);
                    ram_rd_en  = (count_reg != '0);
                    ram_rd_addr = AW'(count_reg >> 1);
                    state_next = dfl_pkg::S_SEARCH;
                end
            end

            dfl_pkg::S_SEARCH:
            begin
                // Narrow [lo, hi) to the first entry whose key is not below the request key
                if (pend_reg)
                begin
                    if (ram_rd_data.key < chk.key)
                    begin
                        lo_t = mid_reg + CW'(1);
                    end
                    else
                    begin
                        hi_t = mid_reg;
                    end
                end
                lo_next  = lo_t;
                hi_next  = hi_t;
                span_sum = {1'b0, lo_t} + {1'b0, hi_t};
                if (lo_t < hi_t)
                begin
                    mid_next    = span_sum[CW:1];
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = span_sum[AW:1];
                    pend_next   = 1'b1;
                end
                else
                begin
                    pos_next   = lo_t;
                    pend_next  = 1'b0;
                    state_next = dfl_pkg::S_PROBE;
                end
            end

            dfl_pkg::S_PROBE:
            begin
                if (pos_reg != count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_reg[AW-1:0];
                    state_next  = dfl_pkg::S_MATCH;
                end
                else if (op_reg == dfl_pkg::OP_LOAD)
                begin
                    // New key above every stored key: append unless full
                    if (table_full)
                    begin
                        res_status_next = dfl_pkg::ST_FULL;
                        state_next      = dfl_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = dfl_pkg::S_INSERT;
                    end
                end
                else if (pos_reg != '0)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(pos_reg - CW'(1));
                    state_next  = dfl_pkg::S_PREV;
                end
                else
                begin
                    state_next = dfl_pkg::S_MUL;
                end
            end

            dfl_pkg::S_MATCH:
            begin
                if (op_reg == dfl_pkg::OP_LOAD)
                begin
                    if (key_eq)
                    begin
                        // Overwrite the rate of an existing date
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = pos_reg[AW-1:0];
                        ram_wr_data.key  = chk.key;
                        ram_wr_data.rate = rate_in_reg;
                        res_status_next  = dfl_pkg::ST_LOADED;
                        state_next       = dfl_pkg::S_DONE;
                    end
                    else if (table_full)
                    begin
                        res_status_next = dfl_pkg::ST_FULL;
                        state_next      = dfl_pkg::S_DONE;
                    end
                    else
                    begin
                        // Start moving the tail up from the last entry
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_reg - CW'(1));
                        sh_next     = AW'(count_reg - CW'(1));
                        state_next  = dfl_pkg::S_SHIFT;
                    end
                end
                else if (key_eq)
                begin
                    used_next  = ram_rd_data.rate;
                    found_next = 1'b1;
                    state_next = dfl_pkg::S_MUL;
                end
                else if (pos_reg != '0)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(pos_reg - CW'(1));
                    state_next  = dfl_pkg::S_PREV;
                end
                else
                begin
                    state_next = dfl_pkg::S_MUL;
                end
            end

            dfl_pkg::S_PREV:
            begin
                used_next  = ram_rd_data.rate;
                found_next = 1'b1;
                state_next = dfl_pkg::S_MUL;
            end

            dfl_pkg::S_SHIFT:
            begin
                // Write entry sh one place up while reading the one below
                ram_wr_en   = 1'b1;
                ram_wr_addr = sh_reg + AW'(1);
                ram_wr_data = ram_rd_data;
                if (CW'(sh_reg) > pos_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = sh_reg - AW'(1);
                    sh_next     = sh_reg - AW'(1);
                end
                else
                begin
                    state_next = dfl_pkg::S_INSERT;
                end
            end

            dfl_pkg::S_INSERT:
            begin
                ram_wr_en        = 1'b1;
                ram_wr_addr      = pos_reg[AW-1:0];
                ram_wr_data.key  = chk.key;
                ram_wr_data.rate = rate_in_reg;
                count_next       = count_reg + CW'(1);
                res_status_next  = dfl_pkg::ST_LOADED;
                state_next       = dfl_pkg::S_DONE;
            end

            dfl_pkg::S_MUL:
            begin
                prod_next = dfl_pkg::PROD_FULL_W'(amt_reg)
                          * dfl_pkg::PROD_FULL_W'(used_reg);
                res_status_next = dfl_pkg::ST_OK;
                state_next      = dfl_pkg::S_DONE;
            end

            dfl_pkg::S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_prod_next   = prod_reg[dfl_pkg::PROD_FULL_W-1:dfl_pkg::FRAC_SHIFT];
                    out_rate_next   = used_reg;
                    out_found_next  = found_reg;
                    state_next      = dfl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dfl_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfl_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rate_in_reg    <= rate_in_next;
        amt_reg        <= amt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        sh_reg         <= sh_next;
        used_reg       <= used_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        prod_reg       <= prod_next;
        out_status_reg <= out_status_next;
        out_prod_reg   <= out_prod_next;
        out_rate_reg   <= out_rate_next;
        out_found_reg  <= out_found_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign product   = out_prod_reg;
    assign rate_used = out_rate_reg;
    assign found     = out_found_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfl_pkg::S_INSERT) |-> (count_reg < CW'(ENTRIES)))
        else $error("insert into a full table");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfl_pkg::S_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search bounds out of order");

    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("memory read and write at the same entry");

    a_load_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == dfl_pkg::ST_LOADED || status == dfl_pkg::ST_FULL))
        |-> (!found && rate_used == '0 && product == '0))
        else $error("load result carries lookup data");

endmodule

// ===== dv/tb_dated_rate_floor_lookup_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_dated_rate_floor_lookup_core: self-checking bench for the dated rate table
// Sends load and query requests through the valid/stall handshake. A sorted
// rate table kept inside the bench predicts every result, and each result is
// checked field by field against the oldest prediction still waiting.
// ============================================================================
module tb_dated_rate_floor_lookup_core;

    localparam int TABLE_DEPTH = 1024;

    // Query window and amount cap (1000.0 in Q19.12), kept apart from the RTL
    localparam int Q_YEAR_LO  = 2009;
    localparam int Q_YEAR_HI  = 2024;
    localparam int Q_MONTH_LO = 1;
    localparam int Q_MONTH_HI = 12;
    localparam int Q_DAY_LO   = 1;
    localparam int Q_DAY_HI   = 31;
    localparam logic [31:0] AMOUNT_CAP = 32'd4096000;
    localparam int FRAC_BITS  = 12;

    // Fill keys sit above every date in the query window, so a fill lands near the top
    localparam logic [dfl_pkg::YEAR_W-1:0] FILL_YEAR = 14'd16383;

    // Quiet time after the last result: covers a load that moves a full table
    localparam int TAIL_CYCLES = 1100;

    // Length of the long output hold
    localparam int HOLD_CYCLES = 150;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              opcode;
    logic [dfl_pkg::YEAR_W-1:0]        year;
    logic [dfl_pkg::MD_W-1:0]          month;
    logic [dfl_pkg::MD_W-1:0]          day;
    logic [dfl_pkg::RATE_W-1:0]        rate;
    logic signed [dfl_pkg::AMT_W-1:0]  amount;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [dfl_pkg::STATUS_W-1:0]      status;
    logic [dfl_pkg::PROD_W-1:0]        product;
    logic [dfl_pkg::RATE_W-1:0]        rate_used;
    logic                              found;

    typedef struct {
        dfl_pkg::status_t              status;
        logic [dfl_pkg::PROD_W-1:0]    product;
        logic [dfl_pkg::RATE_W-1:0]    rate_used;
        logic                          found;
    } rate_result_t;

    // Bench copy of the rate table and the results still owed by the block
    logic [31:0]                table_keys [TABLE_DEPTH];
    logic [dfl_pkg::RATE_W-1:0] table_rates [TABLE_DEPTH];
    int unsigned                table_count;
    rate_result_t               owed_results[$];
    rate_result_t               oldest_owed;

    int unsigned mismatch_count = 0;
    int unsigned send_gap_pct;
    int unsigned stall_pct;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_cycles_left = 0;
    int unsigned fill_idx;

    dated_rate_floor_lookup_core #(
        .ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .year(year),
        .month(month),
        .day(day),
        .rate(rate),
        .amount(amount),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .product(product),
        .rate_used(rate_used),
        .found(found)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] date_key(logic [dfl_pkg::YEAR_W-1:0] y,
                                             logic [dfl_pkg::MD_W-1:0] m,
                                             logic [dfl_pkg::MD_W-1:0] d);
        return 32'(y) * 32'd10000 + 32'(m) * 32'd100 + 32'(d);
    endfunction

    // Split a key back into fields that rebuild the same key
    function automatic void split_key(input logic [31:0] k,
                                      output logic [dfl_pkg::YEAR_W-1:0] y,
                                      output logic [dfl_pkg::MD_W-1:0] m,
                                      output logic [dfl_pkg::MD_W-1:0] d);
        logic [31:0] yq;
        logic [31:0] rest;
        logic [31:0] mq;
        yq = k / 32'd10000;
        if (yq > 32'd16383)
            yq = 32'd16383;
        rest = k - yq * 32'd10000;
        mq = rest / 32'd100;
        if (mq > 32'd127)
            mq = 32'd127;
        y = dfl_pkg::YEAR_W'(yq);
        m = dfl_pkg::MD_W'(mq);
        d = dfl_pkg::MD_W'(rest - mq * 32'd100);
    endfunction

    // First slot whose key is not below the given key
    function automatic int unsigned first_slot_at_or_above(logic [31:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = table_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Apply one request to the bench table and return the result it owes
    function automatic rate_result_t predict_rate_lookup(logic op,
                                                         logic [dfl_pkg::YEAR_W-1:0] y,
                                                         logic [dfl_pkg::MD_W-1:0] m,
                                                         logic [dfl_pkg::MD_W-1:0] d,
                                                         logic [dfl_pkg::RATE_W-1:0] r,
                                                         logic [31:0] a);
        rate_result_t res;
        logic [31:0]  key;
        int unsigned  pos;
        int unsigned  i;
        logic [63:0]  full_product;
        res = '{dfl_pkg::ST_OK, '0, '0, 1'b0};
        key = date_key(y, m, d);
        pos = first_slot_at_or_above(key);
        if (op == dfl_pkg::OP_LOAD)
        begin
            if (pos < table_count && table_keys[pos] == key)
            begin
                table_rates[pos] = r;
                res.status = dfl_pkg::ST_LOADED;
            end
            else if (table_count >= TABLE_DEPTH)
                res.status = dfl_pkg::ST_FULL;
            else
            begin
                for (i = table_count; i > pos; i--)
                begin
                    table_keys[i]  = table_keys[i-1];
                    table_rates[i] = table_rates[i-1];
                end
                table_keys[pos]  = key;
                table_rates[pos] = r;
                table_count++;
                res.status = dfl_pkg::ST_LOADED;
            end
        end
        else if (y < Q_YEAR_LO || y > Q_YEAR_HI || m < Q_MONTH_LO || m > Q_MONTH_HI ||
                 d < Q_DAY_LO || d > Q_DAY_HI)
            res.status = dfl_pkg::ST_BAD_DATE;
        else if (a[31])
            res.status = dfl_pkg::ST_NEGATIVE;
        else if (a > AMOUNT_CAP)
            res.status = dfl_pkg::ST_TOO_LARGE;
        else
        begin
            if (pos < table_count && table_keys[pos] == key)
            begin
                res.rate_used = table_rates[pos];
                res.found = 1'b1;
            end
            else if (pos > 0)
            begin
                res.rate_used = table_rates[pos-1];
                res.found = 1'b1;
            end
            full_product = 64'(a) * 64'(res.rate_used);
            res.product = full_product[FRAC_BITS +: dfl_pkg::PROD_W];
        end
        return res;
    endfunction

    // Offer one request at a falling edge and hold it until the block takes it.
    // Valid stays high on return; the next call or the caller decides to drop it.
    task automatic send_request(input logic op, input logic [dfl_pkg::YEAR_W-1:0] y,
                                input logic [dfl_pkg::MD_W-1:0] m,
                                input logic [dfl_pkg::MD_W-1:0] d,
                                input logic [dfl_pkg::RATE_W-1:0] r,
                                input logic [dfl_pkg::AMT_W-1:0] a);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        year     <= y;
        month    <= m;
        day      <= d;
        rate     <= r;
        amount   <= a;
        owed_results.push_back(predict_rate_lookup(op, y, m, d, r, a));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Mostly well-formed loads and lookups; the rest are errors and odd keys
    task automatic send_random_request();
        int unsigned                pick;
        int unsigned                idx;
        logic [dfl_pkg::YEAR_W-1:0] y;
        logic [dfl_pkg::MD_W-1:0]   m;
        logic [dfl_pkg::MD_W-1:0]   d;
        logic [31:0]                a;
        pick = $urandom_range(99);
        y = dfl_pkg::YEAR_W'($urandom_range(Q_YEAR_HI, Q_YEAR_LO));
        m = dfl_pkg::MD_W'($urandom_range(Q_MONTH_HI, Q_MONTH_LO));
        d = dfl_pkg::MD_W'($urandom_range(Q_DAY_HI, Q_DAY_LO));
        if ($urandom_range(9) == 0)
            a = $urandom_range(1) ? AMOUNT_CAP : 32'd0;
        else
            a = $urandom_range(AMOUNT_CAP, 0);
        if (pick < 25)
            send_request(dfl_pkg::OP_LOAD, y, m, d, $urandom(), $urandom());
        else if (pick < 30)
            send_request(dfl_pkg::OP_LOAD, dfl_pkg::YEAR_W'($urandom_range(16383, 0)),
                         dfl_pkg::MD_W'($urandom_range(127, 0)),
                         dfl_pkg::MD_W'($urandom_range(127, 0)),
                         $urandom(), $urandom());
        else if (pick < 55)
            send_request(dfl_pkg::OP_QUERY, y, m, d, $urandom(), a);
        else if (pick < 75)
        begin
            // hit a stored key exactly when there is one
            if (table_count > 0)
            begin
                idx = $urandom_range(table_count - 1, 0);
                split_key(table_keys[idx], y, m, d);
            end
            send_request(dfl_pkg::OP_QUERY, y, m, d, $urandom(), a);
        end
        else if (pick < 85)
            send_request(dfl_pkg::OP_QUERY, dfl_pkg::YEAR_W'($urandom_range(16383, 0)),
                         dfl_pkg::MD_W'($urandom_range(127, 0)),
                         dfl_pkg::MD_W'($urandom_range(127, 0)),
                         $urandom(), $urandom());
        else if (pick < 92)
            send_request(dfl_pkg::OP_QUERY, y, m, d, $urandom(),
                         $urandom() | 32'h8000_0000);
        else
            send_request(dfl_pkg::OP_QUERY, y, m, d, $urandom(),
                         $urandom_range(32'h7FFF_FFFF, AMOUNT_CAP + 32'd1));
    endtask

    task automatic test_directed_cases();
        send_gap_pct = 0;
        stall_pct    = 0;
        // lookup on an empty table finds nothing
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd15, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_LOAD, 14'd2010, 7'd1, 7'd1, 32'h0000_0100, 32'd0);
        send_request(dfl_pkg::OP_LOAD, 14'd2020, 7'd12, 7'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // insert between two entries, then overwrite the same date
        send_request(dfl_pkg::OP_LOAD, 14'd2015, 7'd6, 7'd15, 32'h1234_5678, 32'd0);
        send_request(dfl_pkg::OP_LOAD, 14'd2015, 7'd6, 7'd15, 32'h0000_0280, 32'd0);
        // date ahead of every entry: no floor
        send_request(dfl_pkg::OP_QUERY, 14'd2009, 7'd12, 7'd31, 32'd0, 32'd0);
        // exact hit at exactly 1000.0
        send_request(dfl_pkg::OP_QUERY, 14'd2010, 7'd1, 7'd1, 32'd0, AMOUNT_CAP);
        // largest rate times largest amount
        send_request(dfl_pkg::OP_QUERY, 14'd2024, 7'd12, 7'd31, 32'd0, AMOUNT_CAP);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd20, 32'd0, 32'd12345);
        // loaded dates are not checked: lowest and highest keys
        send_request(dfl_pkg::OP_LOAD, 14'd0, 7'd0, 7'd0, 32'd0, 32'd0);
        send_request(dfl_pkg::OP_LOAD, 14'd16383, 7'd127, 7'd127, 32'h8000_0000, 32'd0);
        // each edge of the date window
        send_request(dfl_pkg::OP_QUERY, 14'd2008, 7'd6, 7'd15, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd2025, 7'd6, 7'd15, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd0, 7'd15, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd13, 7'd15, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd0, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd32, 32'd0, 32'd4096);
        send_request(dfl_pkg::OP_QUERY, 14'd16383, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'd4096);
        // date check wins over a negative amount
        send_request(dfl_pkg::OP_QUERY, 14'd2030, 7'd6, 7'd15, 32'd0, 32'hFFFF_FFFF);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd15, 32'd0, 32'h8000_0000);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd15, 32'd0, 32'hFFFF_FFFF);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd15, 32'd0, AMOUNT_CAP + 32'd1);
        send_request(dfl_pkg::OP_QUERY, 14'd2015, 7'd6, 7'd15, 32'd0, 32'h7FFF_FFFF);
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned gap,
                                       input int unsigned stall);
        int unsigned n;
        send_gap_pct = gap;
        stall_pct    = stall;
        for (n = 0; n < count; n++)
            send_random_request();
    endtask

    // Hold the output off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        int unsigned n;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_requests++;
        for (n = 0; n < 12; n++)
            send_random_request();
    endtask

    task automatic test_full_table();
        int unsigned                n;
        int unsigned                idx;
        logic [dfl_pkg::YEAR_W-1:0] y;
        logic [dfl_pkg::MD_W-1:0]   m;
        logic [dfl_pkg::MD_W-1:0]   d;
        send_gap_pct = 7;
        stall_pct    = 55;
        while (table_count < TABLE_DEPTH)
        begin
            send_request(dfl_pkg::OP_LOAD, FILL_YEAR, dfl_pkg::MD_W'(fill_idx / 100),
                         dfl_pkg::MD_W'(fill_idx % 100), $urandom(), $urandom());
            fill_idx++;
        end
        // a new key into a full table is refused
        for (n = 0; n < 4; n++)
        begin
            send_request(dfl_pkg::OP_LOAD, FILL_YEAR, dfl_pkg::MD_W'(fill_idx / 100),
                         dfl_pkg::MD_W'(fill_idx % 100), $urandom(), $urandom());
            fill_idx++;
        end
        // an existing key still takes a new rate
        for (n = 0; n < 4; n++)
        begin
            idx = $urandom_range(TABLE_DEPTH - 1, 0);
            split_key(table_keys[idx], y, m, d);
            send_request(dfl_pkg::OP_LOAD, y, m, d, $urandom(), $urandom());
        end
        for (n = 0; n < 20; n++)
            send_random_request();
    endtask

    // Drive the output stall: a requested hold first, else random stalls
    always @(negedge clk)
    begin
        if (holds_started != hold_requests)
        begin
            holds_started    = hold_requests;
            hold_cycles_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_cycles_left > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles_left--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check every taken result against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with none owed: status %0d", status);
                mismatch_count++;
            end
            else
            begin
                oldest_owed = owed_results.pop_front();
                if (status !== oldest_owed.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_owed.status, status);
                    mismatch_count++;
                end
                if (product !== oldest_owed.product)
                begin
                    $error("product: expected %h, got %h", oldest_owed.product, product);
                    mismatch_count++;
                end
                if (rate_used !== oldest_owed.rate_used)
                begin
                    $error("rate_used: expected %h, got %h", oldest_owed.rate_used, rate_used);
                    mismatch_count++;
                end
                if (found !== oldest_owed.found)
                begin
                    $error("found: expected %0d, got %0d", oldest_owed.found, found);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        opcode           = dfl_pkg::OP_LOAD;
        year             = '0;
        month            = '0;
        day              = '0;
        rate             = '0;
        amount           = '0;
        table_count      = 0;
        send_gap_pct     = 0;
        stall_pct        = 0;
        fill_idx         = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(35, 7, 55);
        test_random_traffic(35, 55, 7);
        test_random_traffic(35, 0, 0);
        test_output_backpressure();
        test_full_table();

        // drop valid, collect what is owed, then watch for stray results
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Give up on a hung handshake
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
